FILE: hw/rtl/lsm_pkg.sv
// lsm_pkg: shared types, constants and register indexes for the literal stream matcher.
// No dependencies; used by every module in hw/rtl.
package lsm_pkg;

   localparam int unsigned LSM_MAX_LITERAL = 16;   // default and upper bound of MAX_LITERAL
   localparam int unsigned LSM_OFFSET_W    = 32;
   localparam int unsigned LSM_LEN_W       = 5;    // pattern_length register, also holds 16
   localparam int unsigned LSM_PATTERN_W   = 64;
   localparam int unsigned LSM_CSR_IDX_W   = 2;

   localparam logic [LSM_OFFSET_W-1:0] LSM_OFFSET_TOP = '1;

   // configuration register indexes
   localparam logic [LSM_CSR_IDX_W-1:0] LSM_REG_PATTERN_LOW  = 2'd0;
   localparam logic [LSM_CSR_IDX_W-1:0] LSM_REG_PATTERN_HIGH = 2'd1;
   localparam logic [LSM_CSR_IDX_W-1:0] LSM_REG_LENGTH       = 2'd2;

   // item held between the history stage and the compare stage
   typedef struct packed {
      logic                    valid;
      logic [LSM_OFFSET_W-1:0] here;   // offset of the newest byte
      logic [LSM_LEN_W-1:0]    seen;   // bytes of this buffer in the history
   } lsm_stage_type;

endpackage

FILE: hw/rtl/lsm_history.sv
// lsm_history: input stage. Shift line of recent bytes, fill count and offset counter.
// Depends on lsm_pkg.
module lsm_history #(
   parameter int unsigned MAX_LITERAL = lsm_pkg::LSM_MAX_LITERAL
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_start_of_buffer,
   input  logic                                 stage_advance,
   output lsm_pkg::lsm_stage_type               stage,
   output logic [MAX_LITERAL-1:0][7:0]          history
);

   lsm_pkg::lsm_stage_type              stage_ff, stage_in;
   logic [MAX_LITERAL-1:0][7:0]         history_ff, history_in;
   logic [lsm_pkg::LSM_OFFSET_W-1:0]    next_offset_ff, next_offset_in;
   logic [lsm_pkg::LSM_OFFSET_W-1:0]    base_offset;
   logic [lsm_pkg::LSM_LEN_W-1:0]       base_seen;
   logic                                accept;

   assign req_stall = stage_ff.valid && !stage_advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      base_offset = req_start_of_buffer ? '0 : next_offset_ff;
      base_seen   = req_start_of_buffer ? '0 : stage_ff.seen;

      stage_in       = stage_ff;
      history_in     = history_ff;
      next_offset_in = next_offset_ff;
      if (stage_advance) begin
         stage_in.valid = 1'b0;
      end
      if (accept) begin
         stage_in.valid = 1'b1;
         stage_in.here  = base_offset;
         stage_in.seen  = (base_seen < lsm_pkg::LSM_LEN_W'(MAX_LITERAL))
                        ? base_seen + 1'b1 : base_seen;
         next_offset_in = (base_offset == lsm_pkg::LSM_OFFSET_TOP)
                        ? base_offset : base_offset + 1'b1;
         history_in[0]  = req_data_byte;
         for (int k = 1; k < MAX_LITERAL; k++) begin
            history_in[k] = req_start_of_buffer ? 8'h00 : history_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         stage_ff.seen  <= '0;
         next_offset_ff <= '0;
      end else begin
         stage_ff.valid <= stage_in.valid;
         stage_ff.seen  <= stage_in.seen;
         next_offset_ff <= next_offset_in;
      end
      stage_ff.here <= stage_in.here;
      history_ff    <= history_in;
   end

   assign stage   = stage_ff;
   assign history = history_ff;

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid && !stage_advance |=> stage_ff.valid && $stable(stage_ff.here))
      else $error("held item lost or changed");

   a_restart_offset: assert property (@(posedge clock) disable iff (reset)
      accept && req_start_of_buffer |=> stage_ff.here == '0 && stage_ff.seen == 1)
      else $error("start of buffer did not restart offsets");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      stage_ff.seen <= lsm_pkg::LSM_LEN_W'(MAX_LITERAL))
      else $error("fill count beyond history depth");

endmodule

FILE: hw/rtl/lsm_compare.sv
// lsm_compare: compares the history with the literal and holds the result register.
// Depends on lsm_pkg.
module lsm_compare #(
   parameter int unsigned MAX_LITERAL = lsm_pkg::LSM_MAX_LITERAL
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lsm_pkg::lsm_stage_type                stage,
   input  logic [MAX_LITERAL-1:0][7:0]           history,
   input  logic [lsm_pkg::LSM_PATTERN_W-1:0]     pattern_low,
   input  logic [lsm_pkg::LSM_PATTERN_W-1:0]     pattern_high,
   input  logic [lsm_pkg::LSM_LEN_W-1:0]         pattern_length,
   output logic                                  stage_advance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lsm_pkg::LSM_OFFSET_W-1:0]      rsp_match_start,
   output logic [lsm_pkg::LSM_OFFSET_W-1:0]      rsp_match_end
);

   logic [15:0][7:0]                    literal;
   logic [lsm_pkg::LSM_LEN_W-1:0]       len_eff;
   logic [lsm_pkg::LSM_LEN_W-1:0]       lit_idx;
   logic                                hit;
   logic                                load;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [lsm_pkg::LSM_OFFSET_W-1:0]    start_ff, start_in;
   logic [lsm_pkg::LSM_OFFSET_W-1:0]    end_ff, end_in;

   assign literal = {pattern_high, pattern_low};
   assign len_eff = (pattern_length > lsm_pkg::LSM_LEN_W'(MAX_LITERAL))
                  ? lsm_pkg::LSM_LEN_W'(MAX_LITERAL) : pattern_length;

   // newest byte lines up with the last literal byte
   always_comb begin
      lit_idx = '0;
      hit     = (len_eff != '0) && (stage.seen >= len_eff);
      for (int k = 0; k < MAX_LITERAL; k++) begin
         lit_idx = len_eff - 1'b1 - lsm_pkg::LSM_LEN_W'(k);
         if ((lsm_pkg::LSM_LEN_W'(k) < len_eff) && (history[k] != literal[lit_idx[3:0]])) begin
            hit = 1'b0;
         end
      end
   end

   assign stage_advance = !rsp_valid_ff || !rsp_stall;
   assign load          = stage_advance && stage.valid && hit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      if (stage_advance) begin
         rsp_valid_in = stage.valid && hit;
      end
      if (load) begin
         start_in = stage.here - lsm_pkg::LSM_OFFSET_W'(len_eff - 1'b1);
         end_in   = stage.here;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_start = start_ff;
   assign rsp_match_end   = end_ff;

   a_span_matches_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> end_ff - start_ff == lsm_pkg::LSM_OFFSET_W'(len_eff - 1'b1))
      else $error("occurrence span differs from literal length");

   a_no_hit_when_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> len_eff != '0)
      else $error("hit reported with zero length literal");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(start_ff) && $stable(end_ff))
      else $error("stalled result lost or changed");

endmodule

FILE: hw/rtl/literal_stream_matcher.sv
// Reports every occurrence, overlaps included, of a literal of up to MAX_LITERAL bytes in a
// byte stream, one byte per item, with start and end offsets of each hit. The block takes one
// byte every clock cycle while req_stall is low. Each item passes a history register stage
// and a compare/result register; a hit shows at rsp_valid once the result register takes it.
// A stalled result holds the compare stage; req_stall rises only once both stages are full.
// Index 3 is ignored. The user must write configuration through csr_* only while no item is
// in flight; the block does not enforce it. Depends on lsm_pkg, lsm_history and lsm_compare.
module literal_stream_matcher #(
   parameter int unsigned MAX_LITERAL = lsm_pkg::LSM_MAX_LITERAL
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_start_of_buffer,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lsm_pkg::LSM_OFFSET_W-1:0]     rsp_match_start,
   output logic [lsm_pkg::LSM_OFFSET_W-1:0]     rsp_match_end,
   input  logic                                 csr_write_enable,
   input  logic [lsm_pkg::LSM_CSR_IDX_W-1:0]    csr_index,
   input  logic [lsm_pkg::LSM_PATTERN_W-1:0]    csr_write_data
);

   logic [lsm_pkg::LSM_PATTERN_W-1:0]   pattern_low_ff, pattern_low_in;
   logic [lsm_pkg::LSM_PATTERN_W-1:0]   pattern_high_ff, pattern_high_in;
   logic [lsm_pkg::LSM_LEN_W-1:0]       pattern_length_ff, pattern_length_in;
   lsm_pkg::lsm_stage_type              stage;
   logic [MAX_LITERAL-1:0][7:0]         history;
   logic                                stage_advance;

   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lsm_pkg::LSM_REG_PATTERN_LOW:  pattern_low_in    = csr_write_data;
            lsm_pkg::LSM_REG_PATTERN_HIGH: pattern_high_in   = csr_write_data;
            lsm_pkg::LSM_REG_LENGTH:
               pattern_length_in = csr_write_data[lsm_pkg::LSM_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         pattern_length_ff <= pattern_length_in;
      end
   end

   lsm_history #(
      .MAX_LITERAL(MAX_LITERAL)
   ) u_history (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_start_of_buffer (req_start_of_buffer),
      .stage_advance       (stage_advance),
      .stage               (stage),
      .history             (history)
   );

   lsm_compare #(
      .MAX_LITERAL(MAX_LITERAL)
   ) u_compare (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .history         (history),
      .pattern_low     (pattern_low_ff),
      .pattern_high    (pattern_high_ff),
      .pattern_length  (pattern_length_ff),
      .stage_advance   (stage_advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_start (rsp_match_start),
      .rsp_match_end   (rsp_match_end)
   );

endmodule
